### rtl/mm3_pkg.sv
// mm3_pkg: shared types and constants of the murmur3 x86_32 byte-stream hasher
// controller states, datapath operation codes, command and status structs
// no dependencies
`default_nettype none

package mm3_pkg;

  localparam logic [31:0] MM_C1      = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2      = 32'h1b873593;
  localparam logic [31:0] MM_N       = 32'he6546b64;
  localparam logic [31:0] MM_F1      = 32'h85ebca6b;
  localparam logic [31:0] MM_F2      = 32'hc2b2ae35;
  localparam logic [31:0] SEED_RESET = 32'd1234;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLK_C1,
    S_BLK_C2,
    S_BLK_MIX,
    S_CLOSE,
    S_TAIL_C1,
    S_TAIL_C2,
    S_FIN_START,
    S_FIN_F1,
    S_FIN_F2,
    S_FIN_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ABSORB,
    OP_K_C1,
    OP_K_C2,
    OP_MIX,
    OP_TAIL_LOAD,
    OP_FIN_START,
    OP_FIN_F1,
    OP_FIN_F2,
    OP_FIN_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic block_done;
    logic tail_nonzero;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

### rtl/mm3_ctrl.sv
// mm3_ctrl: controller state machine of the murmur3 hasher
// sequences datapath operations per item; uses mm3_pkg
`default_nettype none

module mm3_ctrl
  import mm3_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  input  wire     last,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.block_done) begin
            state_next = S_BLK_C1;
          end else if (last) begin
            state_next = S_CLOSE;
          end
        end
      end
      S_BLK_C1:  state_next = S_BLK_C2;
      S_BLK_C2:  state_next = S_BLK_MIX;
      S_BLK_MIX: state_next = last ? S_CLOSE : S_IDLE;
      S_CLOSE:   state_next = status.tail_nonzero ? S_TAIL_C1 : S_FIN_START;
      S_TAIL_C1: state_next = S_TAIL_C2;
      S_TAIL_C2: state_next = S_FIN_START;
      S_FIN_START: state_next = S_FIN_F1;
      S_FIN_F1:  state_next = S_FIN_F2;
      S_FIN_F2:  state_next = S_FIN_OUT;
      S_FIN_OUT: begin
        if (!status.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // last stays on the port only until the item is taken; it is read again
  // after the block mix, so the top level hands in a registered copy then
  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.op       = OP_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ABSORB;
        end
      end
      S_BLK_C1, S_TAIL_C1: cmd.op = OP_K_C1;
      S_BLK_C2, S_TAIL_C2: cmd.op = OP_K_C2;
      S_BLK_MIX:   cmd.op = OP_MIX;
      S_CLOSE:     cmd.op = OP_TAIL_LOAD;
      S_FIN_START: cmd.op = OP_FIN_START;
      S_FIN_F1:    cmd.op = OP_FIN_F1;
      S_FIN_F2:    cmd.op = OP_FIN_F2;
      S_FIN_OUT: begin
        if (!status.out_busy) begin
          cmd.op = OP_FIN_OUT;
        end
      end
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/mm3_datapath.sv
// mm3_datapath: murmur3 hash state, shared 32x32 multiplier and result register
// executes one operation per cycle as commanded; uses mm3_pkg
`default_nettype none

module mm3_datapath
  import mm3_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  cmd_t        cmd,
  input  wire  [7:0]  data_byte,
  input  wire         byte_present,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata,
  input  wire         out_ready,
  output status_t     status,
  output logic [31:0] hash,
  output logic        out_valid
);

  logic [31:0] seed;
  logic [31:0] running_hash;
  logic [23:0] partial_word;
  logic [1:0]  bytes_in_word;
  logic [31:0] message_length;
  logic        in_message;
  logic [31:0] work;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] mix_x;
  logic [31:0] mix_r;
  logic [31:0] mix_h;
  logic [31:0] fin_x;
  logic        tail_nonzero;

  assign tail_nonzero = (bytes_in_word != 2'd0);

  // one shared multiplier, low 32 bits of the product
  always_comb begin
    mul_a = work;
    mul_b = MM_C1;
    case (cmd.op)
      OP_K_C2: begin
        mul_a = {work[16:0], work[31:17]};
        mul_b = MM_C2;
      end
      OP_FIN_F1: begin
        mul_a = work;
        mul_b = MM_F1;
      end
      OP_FIN_F2: begin
        mul_a = work ^ {13'd0, work[31:13]};
        mul_b = MM_F2;
      end
      default: begin
        mul_a = work;
        mul_b = MM_C1;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;

  // h = rotl(h ^ k, 13) * 5 + n
  assign mix_x = running_hash ^ work;
  assign mix_r = {mix_x[18:0], mix_x[31:19]};
  assign mix_h = mix_r + {mix_r[29:0], 2'b00} + MM_N;

  always_comb begin
    fin_x = (in_message ? running_hash : seed) ^ message_length;
    if (tail_nonzero) begin
      fin_x = fin_x ^ work;
    end
  end

  assign status.block_done   = byte_present && (bytes_in_word == 2'd3);
  assign status.tail_nonzero = tail_nonzero;
  assign status.out_busy     = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed           <= SEED_RESET;
      running_hash   <= SEED_RESET;
      partial_word   <= 24'd0;
      bytes_in_word  <= 2'd0;
      message_length <= 32'd0;
      in_message     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // a new hash only loads once the previous one is taken or gone
      if (cmd.op == OP_FIN_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_ABSORB: begin
          if (byte_present) begin
            in_message     <= 1'b1;
            message_length <= message_length + 32'd1;
            if (bytes_in_word == 2'd3) begin
              work          <= {data_byte, partial_word};
              partial_word  <= 24'd0;
              bytes_in_word <= 2'd0;
            end else begin
              case (bytes_in_word)
                2'd0:    partial_word[7:0]   <= data_byte;
                2'd1:    partial_word[15:8]  <= data_byte;
                default: partial_word[23:16] <= data_byte;
              endcase
              bytes_in_word <= bytes_in_word + 2'd1;
            end
          end
        end
        OP_K_C1, OP_K_C2, OP_FIN_F1, OP_FIN_F2: begin
          work <= prod;
        end
        OP_MIX: begin
          running_hash <= mix_h;
        end
        OP_TAIL_LOAD: begin
          work <= {8'd0, partial_word};
        end
        OP_FIN_START: begin
          work <= fin_x ^ {16'd0, fin_x[31:16]};
        end
        OP_FIN_OUT: begin
          hash           <= work ^ {16'd0, work[31:16]};
          running_hash   <= seed;
          partial_word   <= 24'd0;
          bytes_in_word  <= 2'd0;
          message_length <= 32'd0;
          in_message     <= 1'b0;
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        seed <= cfg_wdata;
        if (!in_message) begin
          running_hash <= cfg_wdata;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/murmur3_32_hash.sv
// murmur3_32_hash: top level of the byte-stream murmur3 x86_32 hasher
// instantiates mm3_ctrl and mm3_datapath; uses mm3_pkg
`default_nettype none

// channel    direction  handshake            payload
// input      in         in_valid/in_ready    data_byte[7:0], byte_present, last
// output     out        out_valid/out_ready  hash[31:0]
// config     in         cfg_we               cfg_wdata[31:0] (seed)
//
// a byte that does not finish a 4-byte block is absorbed in idle; one that
// finishes a block adds two multiplier passes for the block key and one mix;
// closing adds a tail load, two key passes for 1 to 3 tail bytes and the
// finalization, all on the one shared multiplier; the hash then sits in an
// output register; the next item is taken while the hash waits; a new close
// stalls in its last step only while an earlier hash is still not taken
// synchronous reset loads seed 1234 and clears the message state
module murmur3_32_hash
  import mm3_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         byte_present,
  input  wire         last,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] hash,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;
  logic    last_held;
  logic    last_ctrl;

  // last is only on the port while the item is offered; hold it for the
  // block mix steps that follow the accept
  always_ff @(posedge clk) begin
    if (rst) begin
      last_held <= 1'b0;
    end else if (in_valid && in_ready) begin
      last_held <= last;
    end
  end

  // in idle the controller looks at the offered item, later at the held copy
  assign last_ctrl = in_ready ? last : last_held;
  assign in_ready  = cmd.in_ready;

  mm3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last_ctrl),
    .status   (status),
    .cmd      (cmd)
  );

  mm3_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_ready),
    .status       (status),
    .hash         (hash),
    .out_valid    (out_valid)
  );

endmodule

`default_nettype wire
